// ===== hdl/sweep_prune_pair_builder_top_defines.svh =====
// ---------------------------------------------------------------------------
// sweep_prune_pair_builder_top_defines
// Assertion macros used by the pair builder back end, spp_back.
// ---------------------------------------------------------------------------
`ifndef SWEEP_PRUNE_PAIR_BUILDER_TOP_DEFINES_SVH
`define SWEEP_PRUNE_PAIR_BUILDER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SPP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sweep prune pair builder: assertion failed");
`define SPP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sweep prune pair builder: assertion failed");
`else
`define SPP_ASSERT_IMP(label, clk, rst, ante, cons)
`define SPP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/spp_pkg.sv =====
// ---------------------------------------------------------------------------
// spp_pkg
// Shared widths, job type and encoder for the sweep-and-prune pair builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spp_pkg;

  localparam int unsigned BODY_W         = 6;
  localparam int unsigned MASK_W         = 64;
  localparam int unsigned MAX_BODIES_DEF = 64;
  localparam int unsigned JOBQ_DEPTH     = 2;
  localparam int unsigned JOBQ_AW        = $clog2(JOBQ_DEPTH);

  typedef struct packed {
    logic [MASK_W-1:0] pending;
    logic [BODY_W-1:0] id;
  } job_t;

  function automatic logic [BODY_W-1:0] onehot_index(input logic [MASK_W-1:0] oh);
    logic [BODY_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < MASK_W; k++) begin
      for (int b = 0; b < BODY_W; b++) begin
        if (((k >> b) & 1) == 1) begin
          idx[b] = idx[b] | oh[k];
        end
      end
    end
    return idx;
  endfunction

endpackage

// ===== hdl/spp_front.sv =====
// ---------------------------------------------------------------------------
// spp_front
// Accepts endpoints, keeps the open mask and queues pair jobs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spp_front #(
  parameter int unsigned MAX_BODIES = spp_pkg::MAX_BODIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [spp_pkg::BODY_W-1:0] body_id,
  input  logic                       is_lower_end,
  input  logic                       last_endpoint,
  output logic                       push,
  output spp_pkg::job_t              push_job,
  input  logic                       full
);
  import spp_pkg::*;

  localparam int unsigned CMP_W = BODY_W + 1;

  logic [MAX_BODIES-1:0] open_mask;
  logic [MAX_BODIES-1:0] open_mask_next;
  logic [MAX_BODIES-1:0] id_bit;
  logic [MAX_BODIES-1:0] pending;
  logic                  accept;
  logic                  id_ok;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign id_ok    = {1'b0, body_id} < CMP_W'(MAX_BODIES);
  assign id_bit   = MAX_BODIES'(1) << body_id;
  assign pending  = open_mask & ~id_bit;

  assign push          = accept && id_ok && is_lower_end && (pending != '0);
  assign push_job.pending = MASK_W'(pending);
  assign push_job.id      = body_id;

  always_comb begin
    open_mask_next = open_mask;
    if (id_ok) begin
      if (is_lower_end) begin
        open_mask_next = open_mask | id_bit;
      end else begin
        open_mask_next = open_mask & ~id_bit;
      end
    end
    if (last_endpoint) begin
      open_mask_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_mask <= '0;
    end else if (accept) begin
      open_mask <= open_mask_next;
    end
  end

endmodule

// ===== hdl/spp_jobq.sv =====
// ---------------------------------------------------------------------------
// spp_jobq
// Short job queue between the endpoint front and the pair emitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spp_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output spp_pkg::job_t pop_job,
  output logic          job_valid
);
  import spp_pkg::*;

  job_t               q [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wr_ptr;
  logic [JOBQ_AW-1:0] rd_ptr;
  logic [JOBQ_AW:0]   count;

  assign full      = count == (JOBQ_AW + 1)'(JOBQ_DEPTH);
  assign job_valid = count != '0;
  assign pop_job   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + JOBQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + JOBQ_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (JOBQ_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (JOBQ_AW + 1)'(1);
      end
    end
  end

endmodule

// ===== hdl/spp_back.sv =====
// ---------------------------------------------------------------------------
// spp_back
// Walks a job's pending mask low bit first; one pair a cycle unless stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sweep_prune_pair_builder_top_defines.svh"

module spp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  input  spp_pkg::job_t              pop_job,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [spp_pkg::BODY_W-1:0] first_body,
  output logic [spp_pkg::BODY_W-1:0] second_body,
  output logic                       last_of_run
);
  import spp_pkg::*;

  logic              busy;
  logic [MASK_W-1:0] cur_mask;
  logic [BODY_W-1:0] cur_id;
  logic [MASK_W-1:0] low_bit;
  logic [MASK_W-1:0] rest;
  logic              advance;

  assign low_bit = cur_mask & (~cur_mask + MASK_W'(1));
  assign rest    = cur_mask & ~low_bit;
  assign advance = busy && (!out_valid || !out_stall);
  assign pop     = !busy && job_valid;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_mask <= pop_job.pending;
      cur_id   <= pop_job.id;
    end else if (advance) begin
      cur_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      first_body  <= onehot_index(low_bit);
      second_body <= cur_id;
      last_of_run <= rest == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (advance && rest == '0) begin
        busy <= 1'b0;
      end
    end
  end

  `SPP_ASSERT_IMP(a_busy_has_work, clk, rst, busy, cur_mask != '0)
  `SPP_ASSERT_IMP(a_pair_distinct, clk, rst, out_valid, first_body != second_body)
  `SPP_ASSERT_NXT(a_run_continues, clk, rst, out_valid && !out_stall && !last_of_run, busy || out_valid)

endmodule

// ===== hdl/sweep_prune_pair_builder_top.sv =====
// ---------------------------------------------------------------------------
// sweep_prune_pair_builder_top
// One-axis sweep-and-prune pair generator.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one sorted interval endpoint per
// transfer: body_id, is_lower_end, last_endpoint.
// Output channel (out_valid / out_stall): one overlap pair per transfer:
// first_body (already open), second_body (just opened), last_of_run on the
// final pair caused by one lower end, pairs in ascending first_body order.
// The front takes one endpoint a cycle while the job queue is not full and
// updates the open mask at once; a lower end with open bodies queues a job
// in a two-entry job queue. The back emits one pair a cycle while out_stall
// is low, by priority-encoding the job's mask; a lower end with n open
// bodies occupies the back while it loads the job and emits its n pairs.
// Upper ends and partnerless lower ends take no back time. The first pair
// passes the job queue, the back's job registers and the pair register.
// in_stall rises while the job queue is full; out_stall holds the pair
// register and stops the back.
// Reset clears the open mask, the queue and the output valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sweep_prune_pair_builder_top #(
  parameter int unsigned MAX_BODIES = spp_pkg::MAX_BODIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [spp_pkg::BODY_W-1:0] body_id,
  input  logic                       is_lower_end,
  input  logic                       last_endpoint,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [spp_pkg::BODY_W-1:0] first_body,
  output logic [spp_pkg::BODY_W-1:0] second_body,
  output logic                       last_of_run
);
  import spp_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic job_valid;
  job_t push_job;
  job_t pop_job;

  spp_front #(
    .MAX_BODIES(MAX_BODIES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .body_id      (body_id),
    .is_lower_end (is_lower_end),
    .last_endpoint(last_endpoint),
    .push         (push),
    .push_job     (push_job),
    .full         (full)
  );

  spp_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .job_valid(job_valid)
  );

  spp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .first_body (first_body),
    .second_body(second_body),
    .last_of_run(last_of_run)
  );

endmodule
